[design/hsvtc_pkg.sv]
// Shared types and constants for the HSV threshold centroid block.
// Used by the front, back and top modules of the block; depends on nothing else.
package hsvtc_pkg;

  // Fixed field widths of the pixel and result words.
  localparam int CHAN_W     = 8;
  localparam int CNT_W      = 23;
  localparam int CENT_W     = 11;
  localparam int FW_W       = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // The match count saturates no higher than its field can show.
  localparam int CNT_FIELD_MAX = 32'h007F_FFFF;

  // Threshold register reset values.
  localparam logic [CHAN_W-1:0] HUE_LOW_RST  = 8'd0;
  localparam logic [CHAN_W-1:0] HUE_HIGH_RST = 8'd179;
  localparam logic [CHAN_W-1:0] SAT_LOW_RST  = 8'd0;
  localparam logic [CHAN_W-1:0] SAT_HIGH_RST = 8'd255;
  localparam logic [CHAN_W-1:0] VAL_LOW_RST  = 8'd0;
  localparam logic [CHAN_W-1:0] VAL_HIGH_RST = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_VAL_LOW  = 3'd4,
    REG_VAL_HIGH = 3'd5
  } cfg_reg_t;

  // Inclusive channel bounds.
  typedef struct packed {
    logic [CHAN_W-1:0] hue_low;
    logic [CHAN_W-1:0] hue_high;
    logic [CHAN_W-1:0] sat_low;
    logic [CHAN_W-1:0] sat_high;
    logic [CHAN_W-1:0] val_low;
    logic [CHAN_W-1:0] val_high;
  } thr_t;

  // Pixel word.
  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
    logic              line_end;
    logic              frame_end;
  } pix_t;

  // Result word.
  typedef struct packed {
    logic [CENT_W-1:0] centroid_col;
    logic [FW_W-1:0]   frame_width;
    logic [CNT_W-1:0]  match_total;
    logic              found;
  } res_t;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

[design/hsvtc_front.sv]
// Front end: threshold registers, pixel classification and frame accumulators.
// Depends on hsvtc_pkg; pushes one frame total per frame-end pixel.
module hsvtc_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hsvtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsvtc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  hsvtc_pkg::pix_t                     pix,
  output logic                                job_valid,
  input  logic                                job_ready,
  output logic [$clog2(MAX_WIDTH)+hsvtc_pkg::CNT_W-1:0] job_sum,
  output logic [hsvtc_pkg::CNT_W-1:0]         job_count,
  output logic [$clog2(MAX_WIDTH+1)-1:0]      job_width
);

  localparam int POS_W = $clog2(MAX_WIDTH);
  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W = hsvtc_pkg::CNT_W;
  localparam int SUM_W = POS_W + CNT_W;
  localparam int PIX_TOTAL = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [CNT_W-1:0] CNT_CAP = (PIX_TOTAL < hsvtc_pkg::CNT_FIELD_MAX) ?
                                         CNT_W'(PIX_TOTAL) :
                                         CNT_W'(hsvtc_pkg::CNT_FIELD_MAX);

  hsvtc_pkg::thr_t   thr;
  logic [COL_W-1:0]  column;
  logic [SUM_W-1:0]  column_sum;
  logic [CNT_W-1:0]  match_count;
  logic [COL_W-1:0]  line_width;

  logic              accept;
  logic              line_close;
  logic              match;
  logic [POS_W-1:0]  pos;
  logic [COL_W-1:0]  col_inc;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic [COL_W-1:0]  width_next;

  // Threshold register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.hue_low  <= hsvtc_pkg::HUE_LOW_RST;
      thr.hue_high <= hsvtc_pkg::HUE_HIGH_RST;
      thr.sat_low  <= hsvtc_pkg::SAT_LOW_RST;
      thr.sat_high <= hsvtc_pkg::SAT_HIGH_RST;
      thr.val_low  <= hsvtc_pkg::VAL_LOW_RST;
      thr.val_high <= hsvtc_pkg::VAL_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsvtc_pkg::REG_HUE_LOW:  thr.hue_low  <= cfg_data;
        hsvtc_pkg::REG_HUE_HIGH: thr.hue_high <= cfg_data;
        hsvtc_pkg::REG_SAT_LOW:  thr.sat_low  <= cfg_data;
        hsvtc_pkg::REG_SAT_HIGH: thr.sat_high <= cfg_data;
        hsvtc_pkg::REG_VAL_LOW:  thr.val_low  <= cfg_data;
        hsvtc_pkg::REG_VAL_HIGH: thr.val_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // A pixel is taken whenever the queue has room for a frame total.
  assign pix_ready  = job_ready;
  assign accept     = pix_valid && pix_ready;
  assign line_close = pix.line_end || pix.frame_end;

  // Classification against the three inclusive windows and the count cap.
  always_comb begin
    match = (pix.hue >= thr.hue_low) && (pix.hue <= thr.hue_high) &&
            (pix.saturation >= thr.sat_low) && (pix.saturation <= thr.sat_high) &&
            (pix.brightness >= thr.val_low) && (pix.brightness <= thr.val_high) &&
            (match_count < CNT_CAP);
    pos = (column < COL_W'(MAX_WIDTH - 1)) ? column[POS_W-1:0] : POS_W'(MAX_WIDTH - 1);
    col_inc = (column < COL_W'(MAX_WIDTH)) ? column + COL_W'(1) : column;
    sum_next   = match ? column_sum + SUM_W'(pos) : column_sum;
    count_next = match ? match_count + CNT_W'(1) : match_count;
    width_next = line_close ? col_inc : line_width;
  end

  // Accumulators; a frame end hands the totals over and clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      column_sum  <= '0;
      match_count <= '0;
      line_width  <= '0;
    end else if (accept) begin
      line_width <= width_next;
      column     <= line_close ? '0 : col_inc;
      if (pix.frame_end) begin
        column_sum  <= '0;
        match_count <= '0;
      end else begin
        column_sum  <= sum_next;
        match_count <= count_next;
      end
    end
  end

  assign job_valid = accept && pix.frame_end;
  assign job_sum   = sum_next;
  assign job_count = count_next;
  assign job_width = width_next;

endmodule

[design/hsvtc_queue.sv]
// Short first-in first-out queue of frame totals between front and back.
// Does not depend on hsvtc_pkg; the word is an opaque vector.
module hsvtc_queue #(
  parameter int W     = 58,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [W-1:0]      mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign wr_ready = (fill != FILL_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

[design/hsvtc_back.sv]
// Back end: restoring divider for the mean column and the result register.
// Depends on hsvtc_pkg for the result word and sequencer states.
module hsvtc_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  logic [$clog2(MAX_WIDTH)+hsvtc_pkg::CNT_W-1:0] job_sum,
  input  logic [hsvtc_pkg::CNT_W-1:0]         job_count,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      job_width,
  output logic                                res_valid,
  input  logic                                res_ready,
  output hsvtc_pkg::res_t                     res
);

  localparam int POS_W  = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W  = hsvtc_pkg::CNT_W;
  localparam int SUM_W  = POS_W + CNT_W;
  localparam int CENT_W = hsvtc_pkg::CENT_W;
  localparam int FW_W   = hsvtc_pkg::FW_W;
  localparam int STEP_W = (POS_W > 1) ? $clog2(POS_W) : 1;

  hsvtc_pkg::bk_state_t state;
  hsvtc_pkg::bk_state_t state_next;

  logic [CNT_W-1:0]  rem;
  logic [POS_W-1:0]  quo;
  logic [CNT_W-1:0]  divisor;
  logic [COL_W-1:0]  width;
  logic [STEP_W-1:0] step;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic              load_res;

  // One quotient bit per cycle; the quotient never exceeds the largest column.
  always_comb begin
    trial = {rem, quo[POS_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = !diff[CNT_W];
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsvtc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshakes.
  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      hsvtc_pkg::BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = hsvtc_pkg::BK_DIV;
        end
      end
      hsvtc_pkg::BK_DIV: begin
        if (step == '0) begin
          state_next = hsvtc_pkg::BK_DONE;
        end
      end
      hsvtc_pkg::BK_DONE: begin
        if (!res_valid || res_ready) begin
          load_res   = 1'b1;
          state_next = hsvtc_pkg::BK_IDLE;
        end
      end
      default: state_next = hsvtc_pkg::BK_IDLE;
    endcase
  end

  // Divider datapath: the high sum bits start below the divisor.
  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      rem     <= job_sum[SUM_W-1:POS_W];
      quo     <= job_sum[POS_W-1:0];
      divisor <= job_count;
      width   <= job_width;
      step    <= STEP_W'(POS_W - 1);
    end else if (state == hsvtc_pkg::BK_DIV) begin
      rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo  <= {quo[POS_W-2:0], fits};
      step <= step - STEP_W'(1);
    end
  end

  // Result register; holds its word until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.found        <= (divisor != '0);
      res.centroid_col <= (divisor != '0) ? CENT_W'(quo) : '0;
      res.frame_width  <= FW_W'(width);
      res.match_total  <= divisor;
    end
  end

endmodule

[design/hsv_threshold_centroid.sv]
// Top level of the HSV threshold centroid block: front, queue and back.
// Depends on hsvtc_pkg, hsvtc_front, hsvtc_queue and hsvtc_back.
//
//   channel   handshake            word
//   -------   ------------------   -------------------------------------------
//   cfg       cfg_we               cfg_index, cfg_data (threshold bounds)
//   pixel     pix_valid/pix_ready  pix: hue, saturation, brightness, marks
//   result    res_valid/res_ready  res: centroid_col, frame_width, match_total,
//                                  found
//
// Pixels are taken one per cycle while the queue has room; the front accumulators do all per-pixel work.
// Each frame-end word is divided in the back by a one-bit-per-cycle restoring
// divider, which takes no new frame total until its result word has been loaded.
// The queue holds two frame totals; pix_ready drops only while it is full.
// Reset is synchronous; it clears all control state and sets the bounds to their reset values.
// A result word waiting on res_ready stalls the back; the front stalls only
// once the queue behind it has filled.
module hsv_threshold_centroid #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hsvtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsvtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  hsvtc_pkg::pix_t                   pix,
  output logic                              res_valid,
  input  logic                              res_ready,
  output hsvtc_pkg::res_t                   res
);

  localparam int POS_W  = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W  = hsvtc_pkg::CNT_W;
  localparam int SUM_W  = POS_W + CNT_W;
  localparam int JOB_W  = SUM_W + CNT_W + COL_W;
  localparam int QDEPTH = 2;

  logic              fr_valid;
  logic              fr_ready;
  logic [SUM_W-1:0]  fr_sum;
  logic [CNT_W-1:0]  fr_count;
  logic [COL_W-1:0]  fr_width;
  logic              bk_valid;
  logic              bk_ready;
  logic [JOB_W-1:0]  bk_job;

  // Pixel classification and accumulation.
  hsvtc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .job_valid(fr_valid),
    .job_ready(fr_ready),
    .job_sum  (fr_sum),
    .job_count(fr_count),
    .job_width(fr_width)
  );

  // Frame totals waiting for the divider.
  hsvtc_queue #(
    .W    (JOB_W),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(fr_valid),
    .wr_ready(fr_ready),
    .wr_data ({fr_sum, fr_count, fr_width}),
    .rd_valid(bk_valid),
    .rd_ready(bk_ready),
    .rd_data (bk_job)
  );

  // Mean column division and result register.
  hsvtc_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(bk_valid),
    .job_ready(bk_ready),
    .job_sum  (bk_job[JOB_W-1 -: SUM_W]),
    .job_count(bk_job[COL_W +: CNT_W]),
    .job_width(bk_job[COL_W-1:0]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // A frame with no match reports a zero centroid.
  a_zero_centroid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.centroid_col == '0))
    else $error("centroid nonzero without a match");

  // The found flag follows the match total.
  a_found_total: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.found == (res.match_total != '0)))
    else $error("found flag disagrees with match total");

  // No result word survives a reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result word valid after reset");

endmodule

[tb/tb.sv]
// Self-checking testbench for hsv_threshold_centroid: drives pixel words, predicts frame totals.
// Depends on hsvtc_pkg and the hsv_threshold_centroid RTL; needs no other file.
module tb;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int LAST_COL     = MAX_WIDTH - 1;
  localparam int COUNT_CAP    = (MAX_WIDTH * MAX_HEIGHT < hsvtc_pkg::CNT_FIELD_MAX) ?
                                MAX_WIDTH * MAX_HEIGHT : hsvtc_pkg::CNT_FIELD_MAX;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 12;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [hsvtc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hsvtc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             pix_valid = 1'b0;
  logic                             pix_ready;
  hsvtc_pkg::pix_t                  pix = '0;
  logic                             res_valid;
  logic                             res_ready = 1'b0;
  hsvtc_pkg::res_t                  res;

  // Predicted block state and thresholds.
  hsvtc_pkg::thr_t bounds;
  logic [11:0]     col_pos;
  logic [32:0]     col_sum;
  logic [22:0]     hit_count;
  logic [11:0]     last_line_width;
  hsvtc_pkg::res_t pending_totals[$];

  int send_idle = 11;
  int recv_idle = 60;
  int mismatches = 0;
  int cycles = 0;

  hsv_threshold_centroid #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle budget; a run that hangs ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The receiver stalls at random according to the current idle rate.
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted result word with the oldest predicted frame total.
  always @(posedge clk) begin
    hsvtc_pkg::res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, res);
        mismatches++;
      end else begin
        want = pending_totals.pop_front();
        check_field("centroid_col", int'(want.centroid_col), int'(res.centroid_col));
        check_field("frame_width", int'(want.frame_width), int'(res.frame_width));
        check_field("match_total", int'(want.match_total), int'(res.match_total));
        check_field("found", int'(want.found), int'(res.found));
      end
    end
  end

  function automatic bit channel_hit(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Advance the predicted accumulators by one accepted pixel word.
  task automatic accumulate_pixel(input hsvtc_pkg::pix_t p);
    logic [11:0]     pos;
    logic [32:0]     mean;
    hsvtc_pkg::res_t total;
    pos = (col_pos < LAST_COL) ? col_pos : 12'(LAST_COL);
    if (channel_hit(p.hue, bounds.hue_low, bounds.hue_high) &&
        channel_hit(p.saturation, bounds.sat_low, bounds.sat_high) &&
        channel_hit(p.brightness, bounds.val_low, bounds.val_high) &&
        hit_count < COUNT_CAP) begin
      col_sum   = col_sum + {21'd0, pos};
      hit_count = hit_count + 23'd1;
    end
    if (col_pos < MAX_WIDTH) col_pos = col_pos + 12'd1;
    if (p.line_end || p.frame_end) begin
      last_line_width = col_pos;
      col_pos = '0;
    end
    if (p.frame_end) begin
      mean = (hit_count != 0) ? col_sum / {10'd0, hit_count} : '0;
      total.centroid_col = mean[hsvtc_pkg::CENT_W-1:0];
      total.frame_width  = last_line_width;
      total.match_total  = hit_count;
      total.found        = (hit_count != 0);
      pending_totals.insert(pending_totals.size(), total);
      col_sum   = '0;
      hit_count = '0;
      col_pos   = '0;
    end
  endtask

  // Offer one pixel word, possibly after a random gap, and wait for acceptance.
  task automatic send_pixel(input hsvtc_pkg::pix_t p);
    while ($urandom_range(99) < send_idle) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    accumulate_pixel(p);
  endtask

  task automatic send_hsv(input int h, input int s, input int v, input bit le, input bit fe);
    hsvtc_pkg::pix_t p;
    p.hue        = h[7:0];
    p.saturation = s[7:0];
    p.brightness = v[7:0];
    p.line_end   = le;
    p.frame_end  = fe;
    send_pixel(p);
  endtask

  // Let every predicted total come out and the back end settle.
  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all threshold registers plus the two unused indexes in one burst.
  task automatic set_bounds(input hsvtc_pkg::thr_t b);
    logic [hsvtc_pkg::CFG_DATA_W-1:0] d;
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      case (i)
        hsvtc_pkg::REG_HUE_LOW:  d = b.hue_low;
        hsvtc_pkg::REG_HUE_HIGH: d = b.hue_high;
        hsvtc_pkg::REG_SAT_LOW:  d = b.sat_low;
        hsvtc_pkg::REG_SAT_HIGH: d = b.sat_high;
        hsvtc_pkg::REG_VAL_LOW:  d = b.val_low;
        hsvtc_pkg::REG_VAL_HIGH: d = b.val_high;
        default:                 d = 8'($urandom_range(255));
      endcase
      cfg_index <= i[hsvtc_pkg::CFG_IDX_W-1:0];
      cfg_data  <= d;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    bounds = b;
  endtask

  function automatic hsvtc_pkg::thr_t make_bounds(input int hl, input int hh, input int sl,
                                                  input int sh, input int vl, input int vh);
    hsvtc_pkg::thr_t b;
    b.hue_low  = hl[7:0];
    b.hue_high = hh[7:0];
    b.sat_low  = sl[7:0];
    b.sat_high = sh[7:0];
    b.val_low  = vl[7:0];
    b.val_high = vh[7:0];
    return b;
  endfunction

  // Channel value biased toward the bound edges and the matching range.
  function automatic logic [7:0] pick_channel(input logic [7:0] lo, input logic [7:0] hi);
    int k;
    k = $urandom_range(7);
    case (k)
      0: return lo;
      1: return hi;
      2: return lo - 8'd1;
      3: return hi + 8'd1;
      4, 5: return (lo <= hi) ? 8'($urandom_range(hi, lo)) : 8'($urandom_range(255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic hsvtc_pkg::pix_t random_pixel(input bit le, input bit fe);
    hsvtc_pkg::pix_t p;
    p.hue        = pick_channel(bounds.hue_low, bounds.hue_high);
    p.saturation = pick_channel(bounds.sat_low, bounds.sat_high);
    p.brightness = pick_channel(bounds.val_low, bounds.val_high);
    p.line_end   = le;
    p.frame_end  = fe;
    return p;
  endfunction

  // A well-formed frame of w columns by h lines with random pixel content.
  task automatic send_frame(input int w, input int h);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        send_pixel(random_pixel(c == w - 1, (r == h - 1) && (c == w - 1)));
      end
    end
  endtask

  // Channel extremes under the reset bounds, an empty frame, frame end alone.
  task automatic test_channel_edges();
    send_hsv(0, 0, 0, 1'b0, 1'b0);
    send_hsv(179, 255, 255, 1'b0, 1'b0);
    send_hsv(180, 128, 128, 1'b0, 1'b0);
    send_hsv(255, 255, 255, 1'b0, 1'b0);
    send_hsv(90, 0, 255, 1'b1, 1'b1);
    // Nothing matches, and the frame end closes its line without a line end.
    send_hsv(200, 10, 10, 1'b0, 1'b0);
    send_hsv(255, 10, 10, 1'b0, 1'b0);
    send_hsv(181, 10, 10, 1'b0, 1'b1);
  endtask

  // Narrow bounds probed just outside and on each edge, crossed bounds, single values.
  task automatic test_bound_extremes();
    wait_idle();
    set_bounds(make_bounds(10, 20, 30, 40, 50, 60));
    send_hsv(9, 35, 55, 1'b0, 1'b0);
    send_hsv(10, 30, 50, 1'b0, 1'b0);
    send_hsv(20, 40, 60, 1'b0, 1'b0);
    send_hsv(21, 35, 55, 1'b1, 1'b0);
    send_hsv(15, 29, 55, 1'b0, 1'b0);
    send_hsv(15, 41, 55, 1'b0, 1'b0);
    send_hsv(15, 35, 49, 1'b0, 1'b0);
    send_hsv(15, 35, 61, 1'b1, 1'b1);
    // A low bound above its high bound never matches.
    wait_idle();
    set_bounds(make_bounds(100, 99, 0, 255, 0, 255));
    send_hsv(99, 0, 0, 1'b0, 1'b0);
    send_hsv(100, 0, 0, 1'b1, 1'b1);
    wait_idle();
    set_bounds(make_bounds(255, 255, 255, 255, 255, 255));
    send_hsv(255, 255, 255, 1'b0, 1'b0);
    send_hsv(254, 255, 255, 1'b0, 1'b0);
    send_hsv(255, 255, 255, 1'b1, 1'b1);
    wait_idle();
    set_bounds(make_bounds(0, 0, 0, 0, 0, 0));
    send_hsv(0, 0, 1, 1'b0, 1'b0);
    send_hsv(0, 0, 0, 1'b1, 1'b1);
  endtask

  // One line past the maximum width: the column holds and the width saturates.
  task automatic test_long_line();
    int n;
    wait_idle();
    set_bounds(make_bounds(0, 255, 0, 255, 0, 255));
    n = MAX_WIDTH + 4;
    for (int c = 0; c < n; c++) begin
      send_pixel(random_pixel(c == n - 1, c == n - 1));
    end
    // A short frame right after checks that the column starts over.
    send_frame(3, 2);
  endtask

  // Mostly well-formed frames of small size, some broken frames and noise.
  task automatic test_random_frames();
    int              items;
    int              kind;
    int              w;
    int              h;
    int              n;
    hsvtc_pkg::thr_t b;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 11; recv_idle = 60; end
        1: begin send_idle = 60; recv_idle = 11; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        case (sub)
          0: b = make_bounds(0, 255, 0, 255, 0, 255);
          1: begin
            w = $urandom_range(255);
            h = $urandom_range(255);
            n = $urandom_range(255);
            b = make_bounds(w, w, h, h, n, n);
          end
          default: b = make_bounds($urandom_range(255), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(255));
        endcase
        // Keep most random bounds ordered so that matches stay common.
        if (sub == 2) begin
          if (b.hue_low > b.hue_high) b = {b.hue_high, b.hue_low, b[31:0]};
          if (b.sat_low > b.sat_high) b = {b[47:32], b.sat_high, b.sat_low, b[15:0]};
          if (b.val_low > b.val_high) b = {b[47:16], b.val_high, b.val_low};
        end
        wait_idle();
        set_bounds(b);
        items = 0;
        while (items < RANDOM_ITEMS) begin
          kind = $urandom_range(9);
          if (kind < 8) begin
            w = $urandom_range(12, 1);
            h = $urandom_range(5, 1);
            send_frame(w, h);
            items += w * h;
          end else if (kind == 8) begin
            // Broken frame: stray line ends, frame end often without a line end.
            n = $urandom_range(20, 1);
            for (int i = 0; i < n; i++) begin
              send_pixel(random_pixel($urandom_range(3) == 0, i == n - 1));
            end
            items += n;
          end else begin
            n = $urandom_range(16, 1);
            for (int i = 0; i < n; i++) begin
              send_pixel(random_pixel($urandom_range(7) == 0, $urandom_range(7) == 0));
            end
            items += n;
          end
        end
      end
    end
  endtask

  initial begin
    bounds.hue_low  = hsvtc_pkg::HUE_LOW_RST;
    bounds.hue_high = hsvtc_pkg::HUE_HIGH_RST;
    bounds.sat_low  = hsvtc_pkg::SAT_LOW_RST;
    bounds.sat_high = hsvtc_pkg::SAT_HIGH_RST;
    bounds.val_low  = hsvtc_pkg::VAL_LOW_RST;
    bounds.val_high = hsvtc_pkg::VAL_HIGH_RST;
    col_pos         = '0;
    col_sum         = '0;
    hit_count       = '0;
    last_line_width = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_channel_edges();
    test_bound_extremes();
    test_long_line();
    test_random_frames();

    wait_idle();
    if (mismatches == 0 && pending_totals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[hsv_threshold_centroid.f]
design/hsvtc_pkg.sv
design/hsvtc_front.sv
design/hsvtc_queue.sv
design/hsvtc_back.sv
design/hsv_threshold_centroid.sv
tb/tb.sv
